FILE: rtl/virtio_pci_common_config_defines.svh
// Assertion macros for the virtio common-configuration block.
// Used by the checker; no other dependencies.
`ifndef VIRTIO_PCI_COMMON_CONFIG_DEFINES_SVH
`define VIRTIO_PCI_COMMON_CONFIG_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VPCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vpcc: implication check failed");

// Next-cycle implication, disabled during reset.
`define VPCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vpcc: next-cycle check failed");

`endif

FILE: rtl/vpcc_pkg.sv
// Shared constants and types for the virtio common-configuration block.
// No dependencies.
package vpcc_pkg;

  localparam int NumQueuesDef = 8;

  localparam logic [15:0] QueueMaxSizeDef = 16'd256;
  localparam logic [15:0] NoVector        = 16'hFFFF;

  localparam logic [1:0] IsrQueue  = 2'b01;
  localparam logic [1:0] IsrConfig = 2'b10;

  localparam logic [7:0] StDriverOk   = 8'h04;
  localparam logic [7:0] StFeaturesOk = 8'h08;
  localparam logic [7:0] StNeedsReset = 8'h40;

  localparam int EventIdxBit = 29;

  localparam logic [2:0] CmdRead      = 3'd0;
  localparam logic [2:0] CmdWrite     = 3'd1;
  localparam logic [2:0] CmdIsrRead   = 3'd2;
  localparam logic [2:0] CmdQueueIrq  = 3'd3;
  localparam logic [2:0] CmdConfigIrq = 3'd4;

  localparam logic [1:0] EvNone     = 2'd0;
  localparam logic [1:0] EvReady    = 2'd1;
  localparam logic [1:0] EvNotReady = 2'd2;

  localparam logic RegDeviceFeatures = 1'b0;
  localparam logic RegQueueMaxSize   = 1'b1;

  localparam logic [5:0] LaneDevFeatSel = 6'h00;
  localparam logic [5:0] LaneDevFeat    = 6'h04;
  localparam logic [5:0] LaneDrvFeatSel = 6'h08;
  localparam logic [5:0] LaneDrvFeat    = 6'h0C;
  localparam logic [5:0] LaneCfgVector  = 6'h10;
  localparam logic [5:0] LaneStatus     = 6'h14;
  localparam logic [5:0] LaneQSize      = 6'h18;
  localparam logic [5:0] LaneQEnable    = 6'h1C;
  localparam logic [5:0] LaneDescLo     = 6'h20;
  localparam logic [5:0] LaneDescHi     = 6'h24;
  localparam logic [5:0] LaneAvailLo    = 6'h28;
  localparam logic [5:0] LaneAvailHi    = 6'h2C;
  localparam logic [5:0] LaneUsedLo     = 6'h30;
  localparam logic [5:0] LaneUsedHi     = 6'h34;

  typedef struct packed {
    logic [15:0] size;
    logic [15:0] vector;
    logic [15:0] enable;
    logic [63:0] desc;
    logic [63:0] avail;
    logic [63:0] used;
  } q_entry_t;

  localparam int QEntryW = $bits(q_entry_t);

  localparam q_entry_t QEntryReset = '{
    size: 16'h0, vector: NoVector, enable: 16'h0,
    desc: 64'h0, avail: 64'h0, used: 64'h0
  };

endpackage

FILE: rtl/vpcc_req_if.sv
// Request channel: one register access or interrupt command per word.
// Depends on nothing.
interface vpcc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [5:0]  offset;
  logic [3:0]  acc_size;
  logic [63:0] write_data;
  logic [15:0] queue_index;

  modport source (output valid, cmd, offset, acc_size, write_data, queue_index,
                  input ready);
  modport sink   (input valid, cmd, offset, acc_size, write_data, queue_index,
                  output ready);
endinterface

FILE: rtl/vpcc_rsp_if.sv
// Response channel: read data, interrupt request and queue events per word.
// Depends on nothing.
interface vpcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        interrupt_fire;
  logic [15:0] interrupt_vector;
  logic [1:0]  queue_event;
  logic [15:0] event_queue;
  logic [63:0] ring_desc;
  logic [63:0] ring_avail;
  logic [63:0] ring_used;
  logic [15:0] ring_size;
  logic        event_idx_on;
  logic        driver_ok_pulse;
  logic        device_reset_pulse;

  modport source (output valid, read_data, interrupt_fire, interrupt_vector, queue_event,
                  event_queue, ring_desc, ring_avail, ring_used, ring_size,
                  event_idx_on, driver_ok_pulse, device_reset_pulse,
                  input ready);
  modport sink   (input valid, read_data, interrupt_fire, interrupt_vector, queue_event,
                  event_queue, ring_desc, ring_avail, ring_used, ring_size,
                  event_idx_on, driver_ok_pulse, device_reset_pulse,
                  output ready);
endinterface

FILE: rtl/vpcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vpcc_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                    wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                    rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/virtio_pci_common_config.sv
// virtio modern PCI common-configuration register file.
// Depends on vpcc_pkg, vpcc_req_if, vpcc_rsp_if and vpcc_ram.
//
// Usage: req_i carries one word per access (common read or write of 1, 2,
// 4 or 8 bytes, ISR read, queue interrupt, config change). rsp_o returns
// exactly one word per request with read data, MSI-X request, queue
// ready/not-ready event and status pulses. Both use valid/ready.
// Each request first reads the queue entry of the selected queue from the
// queue-table RAM, then merges, decides and writes it back. A new request
// is taken in the cycle after the previous one commits, so requests do not
// overlap: only one is in flight at a time.
// The result sits in an output register; a stalled receiver holds the
// request in its execute cycle until the register drains, while a finished
// result waiting does not block acceptance.
// The APB port sets device_features (address 0) and queue_max_size
// (address 8); write it only while no request is in flight.
// Reset is immediate: per-queue valid bits clear the queue table, so no
// clearing pass runs, and a zero status write clears it the same way.
module virtio_pci_common_config #(
  parameter int QueueCount = vpcc_pkg::NumQueuesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpcc_req_if.sink    req_i,
  vpcc_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int QW = QueueCount > 1 ? $clog2(QueueCount) : 1;
  localparam logic [15:0] NumQ = 16'(QueueCount);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  typedef struct packed {
    logic [31:0]        dfsel;
    logic [31:0]        drfsel;
    logic [63:0]        drvfeat;
    logic [15:0]        cfgvec;
    logic [7:0]         status;
    logic [7:0]         gen;
    logic [15:0]        qsel;
    logic [1:0]         isr;
    vpcc_pkg::q_entry_t ent;
    logic               qclr;
    logic [63:0]        rdata;
    logic               fire;
    logic [15:0]        vec;
    logic [1:0]         qev;
    logic [15:0]        evq;
    logic [63:0]        rdesc;
    logic [63:0]        ravail;
    logic [63:0]        rused;
    logic [15:0]        rsize;
    logic               eidx;
    logic               dok;
    logic               drst;
  } ctx_t;

  state_e state_q;
  logic [63:0] dev_feat_q;
  logic [15:0] qmax_q;
  logic [31:0] dfsel_q, drfsel_q;
  logic [63:0] drvfeat_q;
  logic [15:0] cfgvec_q, qsel_q;
  logic [7:0]  status_q, gen_q;
  logic [1:0]  isr_q;
  logic [QueueCount-1:0] qvalid_q;

  logic [2:0]  cmd_q;
  logic [5:0]  off_q;
  logic [3:0]  size_q;
  logic [63:0] wdata_q;
  logic [15:0] qidx_q;
  logic [QW-1:0] idx_q;

  logic        out_valid_q;
  ctx_t        out_q;

  logic               req_fire, commit, ram_we;
  logic [QW-1:0]      ram_raddr;
  vpcc_pkg::q_entry_t ram_rdata, ent_cur;
  ctx_t               c;

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] lane_read(input ctx_t s, input logic [5:0] off,
                                            input logic [63:0] devf,
                                            input logic [15:0] qmax);
    logic        ok;
    logic [31:0] r;
    ok = s.qsel < NumQ;
    case (off)
      vpcc_pkg::LaneDevFeatSel: r = s.dfsel;
      vpcc_pkg::LaneDevFeat:
        r = (s.dfsel == 32'd0) ? devf[31:0] : (s.dfsel == 32'd1) ? devf[63:32] : 32'h0;
      vpcc_pkg::LaneDrvFeatSel: r = s.drfsel;
      vpcc_pkg::LaneDrvFeat:
        r = (s.drfsel == 32'd0) ? s.drvfeat[31:0] :
            (s.drfsel == 32'd1) ? s.drvfeat[63:32] : 32'h0;
      vpcc_pkg::LaneCfgVector: r = {NumQ, s.cfgvec};
      vpcc_pkg::LaneStatus:    r = {s.qsel, s.gen, s.status};
      vpcc_pkg::LaneQSize:
        r = ok ? {s.ent.vector, (s.ent.size != 16'h0) ? s.ent.size : qmax}
               : {vpcc_pkg::NoVector, 16'h0};
      vpcc_pkg::LaneQEnable: r = {s.qsel, ok ? s.ent.enable : 16'h0};
      vpcc_pkg::LaneDescLo:  r = ok ? s.ent.desc[31:0]   : 32'h0;
      vpcc_pkg::LaneDescHi:  r = ok ? s.ent.desc[63:32]  : 32'h0;
      vpcc_pkg::LaneAvailLo: r = ok ? s.ent.avail[31:0]  : 32'h0;
      vpcc_pkg::LaneAvailHi: r = ok ? s.ent.avail[63:32] : 32'h0;
      vpcc_pkg::LaneUsedLo:  r = ok ? s.ent.used[31:0]   : 32'h0;
      vpcc_pkg::LaneUsedHi:  r = ok ? s.ent.used[63:32]  : 32'h0;
      default:               r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic ctx_t lane_write(input ctx_t si, input logic [5:0] off,
                                      input logic [31:0] v, input logic [63:0] devf,
                                      input logic [15:0] qmax);
    ctx_t       s;
    logic       ok;
    logic [7:0] adding, eff;
    s = si;
    ok = s.qsel < NumQ;
    case (off)
      vpcc_pkg::LaneDevFeatSel: s.dfsel = v;
      vpcc_pkg::LaneDrvFeatSel: s.drfsel = v;
      vpcc_pkg::LaneDrvFeat: begin
        if (s.drfsel == 32'd0) s.drvfeat[31:0] = v;
        else if (s.drfsel == 32'd1) s.drvfeat[63:32] = v;
      end
      vpcc_pkg::LaneCfgVector: s.cfgvec = v[15:0];
      vpcc_pkg::LaneStatus: begin
        if (v[7:0] != s.status) begin
          if (v[7:0] == 8'h0) begin
            s.status  = 8'h0;
            s.isr     = 2'b00;
            s.dfsel   = 32'h0;
            s.drfsel  = 32'h0;
            s.drvfeat = 64'h0;
            s.cfgvec  = vpcc_pkg::NoVector;
            s.ent     = vpcc_pkg::QEntryReset;
            s.qclr    = 1'b1;
            s.drst    = 1'b1;
          end else begin
            adding = v[7:0] & ~s.status;
            eff = v[7:0];
            if ((adding & vpcc_pkg::StFeaturesOk) != 8'h0 &&
                (s.drvfeat & ~devf) != 64'h0) begin
              eff = (eff & ~vpcc_pkg::StFeaturesOk) | vpcc_pkg::StNeedsReset;
            end
            s.status = eff;
            if ((adding & vpcc_pkg::StDriverOk) != 8'h0) s.dok = 1'b1;
          end
        end
        s.qsel = v[31:16];
      end
      vpcc_pkg::LaneQSize: begin
        if (ok) begin
          if (v[15:0] <= qmax) s.ent.size = v[15:0];
          s.ent.vector = v[31:16];
        end
      end
      vpcc_pkg::LaneQEnable: begin
        if (ok) begin
          s.ent.enable = v[15:0];
          if (v[15:0] != 16'h0 && s.ent.size != 16'h0) begin
            s.qev    = vpcc_pkg::EvReady;
            s.evq    = s.qsel;
            s.rdesc  = s.ent.desc;
            s.ravail = s.ent.avail;
            s.rused  = s.ent.used;
            s.rsize  = s.ent.size;
            s.eidx   = s.drvfeat[vpcc_pkg::EventIdxBit];
          end else if (v[15:0] == 16'h0) begin
            s.qev = vpcc_pkg::EvNotReady;
            s.evq = s.qsel;
          end
        end
      end
      vpcc_pkg::LaneDescLo:  if (ok) s.ent.desc[31:0]   = v;
      vpcc_pkg::LaneDescHi:  if (ok) s.ent.desc[63:32]  = v;
      vpcc_pkg::LaneAvailLo: if (ok) s.ent.avail[31:0]  = v;
      vpcc_pkg::LaneAvailHi: if (ok) s.ent.avail[63:32] = v;
      vpcc_pkg::LaneUsedLo:  if (ok) s.ent.used[31:0]   = v;
      vpcc_pkg::LaneUsedHi:  if (ok) s.ent.used[63:32]  = v;
      default: ;
    endcase
    return s;
  endfunction

  vpcc_ram #(
    .Width(vpcc_pkg::QEntryW),
    .Depth(QueueCount)
  ) u_qtab (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(c.ent),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign ram_raddr   = (state_q != ST_IDLE) ? idx_q :
                       (req_i.cmd == vpcc_pkg::CmdQueueIrq) ? req_i.queue_index[QW-1:0]
                                                            : qsel_q[QW-1:0];
  assign ent_cur     = qvalid_q[idx_q] ? ram_rdata : vpcc_pkg::QEntryReset;
  assign commit      = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);
  assign ram_we      = commit && (cmd_q == vpcc_pkg::CmdWrite) && !c.qclr &&
                       (qsel_q < NumQ);

  always_comb begin
    logic [2:0]  n;
    logic        wide;
    logic [5:0]  aligned;
    logic [4:0]  shift;
    logic [31:0] mask, v, cur;
    n       = (size_q < 4'd4) ? size_q[2:0] : 3'd4;
    wide    = (size_q == 4'd8) && (off_q[2:0] == 3'b000);
    aligned = {off_q[5:2], 2'b00};
    shift   = {off_q[1:0], 3'b000};
    mask    = byte_mask(n);
    v       = wdata_q[31:0] & mask;
    c = '0;
    c.dfsel   = dfsel_q;
    c.drfsel  = drfsel_q;
    c.drvfeat = drvfeat_q;
    c.cfgvec  = cfgvec_q;
    c.status  = status_q;
    c.gen     = gen_q;
    c.qsel    = qsel_q;
    c.isr     = isr_q;
    c.ent     = ent_cur;
    cur = lane_read(c, aligned, dev_feat_q, qmax_q);
    case (cmd_q)
      vpcc_pkg::CmdRead: begin
        if (wide) begin
          c.rdata = {lane_read(c, off_q + 6'd4, dev_feat_q, qmax_q),
                     lane_read(c, off_q, dev_feat_q, qmax_q)};
        end else begin
          c.rdata = {32'h0, (cur >> shift) & mask};
        end
      end
      vpcc_pkg::CmdWrite: begin
        if (wide) begin
          c = lane_write(c, off_q, wdata_q[31:0], dev_feat_q, qmax_q);
          c = lane_write(c, off_q + 6'd4, wdata_q[63:32], dev_feat_q, qmax_q);
        end else if (n != 3'd0) begin
          if (size_q < 4'd4) begin
            c = lane_write(c, aligned, (cur & ~(mask << shift)) | (v << shift),
                           dev_feat_q, qmax_q);
          end else begin
            c = lane_write(c, aligned, v, dev_feat_q, qmax_q);
          end
        end
      end
      vpcc_pkg::CmdIsrRead: begin
        c.rdata = {62'h0, (n != 3'd0) ? isr_q : 2'b00};
        c.isr   = 2'b00;
      end
      vpcc_pkg::CmdQueueIrq: begin
        c.isr = isr_q | vpcc_pkg::IsrQueue;
        if (qidx_q < NumQ && ent_cur.vector != vpcc_pkg::NoVector) begin
          c.fire = 1'b1;
          c.vec  = ent_cur.vector;
        end
      end
      vpcc_pkg::CmdConfigIrq: begin
        c.isr = isr_q | vpcc_pkg::IsrConfig;
        c.gen = gen_q + 8'd1;
        if (cfgvec_q != vpcc_pkg::NoVector) begin
          c.fire = 1'b1;
          c.vec  = cfgvec_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dev_feat_q  <= 64'h0;
      qmax_q      <= vpcc_pkg::QueueMaxSizeDef;
      dfsel_q     <= 32'h0;
      drfsel_q    <= 32'h0;
      drvfeat_q   <= 64'h0;
      cfgvec_q    <= vpcc_pkg::NoVector;
      status_q    <= 8'h0;
      gen_q       <= 8'h0;
      qsel_q      <= 16'h0;
      isr_q       <= 2'b00;
      qvalid_q    <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3])
          vpcc_pkg::RegDeviceFeatures: dev_feat_q <= pwdata;
          vpcc_pkg::RegQueueMaxSize:   qmax_q     <= pwdata[15:0];
          default: ;
        endcase
      end
      if (commit) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (req_fire) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (commit) begin
            state_q     <= ST_IDLE;
            dfsel_q     <= c.dfsel;
            drfsel_q    <= c.drfsel;
            drvfeat_q   <= c.drvfeat;
            cfgvec_q    <= c.cfgvec;
            status_q    <= c.status;
            gen_q       <= c.gen;
            qsel_q      <= c.qsel;
            isr_q       <= c.isr;
            if (c.qclr) qvalid_q <= '0;
            else if (ram_we) qvalid_q[idx_q] <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q   <= req_i.cmd;
      off_q   <= req_i.offset;
      size_q  <= req_i.acc_size;
      wdata_q <= req_i.write_data;
      qidx_q  <= req_i.queue_index;
      idx_q   <= ram_raddr;
    end
    if (commit) out_q <= c;
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.read_data          = out_q.rdata;
  assign rsp_o.interrupt_fire     = out_q.fire;
  assign rsp_o.interrupt_vector   = out_q.vec;
  assign rsp_o.queue_event        = out_q.qev;
  assign rsp_o.event_queue        = out_q.evq;
  assign rsp_o.ring_desc          = out_q.rdesc;
  assign rsp_o.ring_avail         = out_q.ravail;
  assign rsp_o.ring_used          = out_q.rused;
  assign rsp_o.ring_size          = out_q.rsize;
  assign rsp_o.event_idx_on       = out_q.eidx;
  assign rsp_o.driver_ok_pulse    = out_q.dok;
  assign rsp_o.device_reset_pulse = out_q.drst;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == vpcc_pkg::RegQueueMaxSize) ? {48'h0, qmax_q} : dev_feat_q;

endmodule

FILE: rtl/vpcc_checker.sv
// Port-level checks for virtio_pci_common_config, bound to the top level.
// Depends on virtio_pci_common_config_defines.svh and vpcc_pkg.
`include "virtio_pci_common_config_defines.svh"

module vpcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [63:0] rsp_read_data_i,
  input logic        rsp_fire_i,
  input logic [15:0] rsp_vector_i,
  input logic [1:0]  rsp_event_i,
  input logic [15:0] rsp_size_i,
  input logic        rsp_dok_i,
  input logic        rsp_drst_i
);
  `VPCC_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
    rsp_valid_i && $stable(rsp_read_data_i))
  `VPCC_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)
  `VPCC_ASSERT_IMP(a_vector_gated, clk_i, rst_ni, rsp_valid_i && !rsp_fire_i,
    rsp_vector_i == 16'h0)
  `VPCC_ASSERT_IMP(a_ring_gated, clk_i, rst_ni,
    rsp_valid_i && rsp_event_i != vpcc_pkg::EvReady, rsp_size_i == 16'h0)
  `VPCC_ASSERT_IMP(a_pulse_excl, clk_i, rst_ni, rsp_valid_i, !(rsp_dok_i && rsp_drst_i))
endmodule

bind virtio_pci_common_config vpcc_checker u_vpcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_read_data_i(rsp_o.read_data),
  .rsp_fire_i     (rsp_o.interrupt_fire),
  .rsp_vector_i   (rsp_o.interrupt_vector),
  .rsp_event_i    (rsp_o.queue_event),
  .rsp_size_i     (rsp_o.ring_size),
  .rsp_dok_i      (rsp_o.driver_ok_pulse),
  .rsp_drst_i     (rsp_o.device_reset_pulse)
);

FILE: dv/vpcc_access_checker.sv
// Checker for the virtio common-configuration block: it watches the request and response words
// and the APB writes, predicts each response and compares it field by field.
// Depends on vpcc_pkg, vpcc_req_if and vpcc_rsp_if.
module vpcc_access_checker #(
  parameter int NQ = vpcc_pkg::NumQueuesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpcc_req_if         req,
  vpcc_rsp_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output int          errors_o,
  output int          pending_o
);
  typedef struct packed {
    logic [63:0] read_data;
    logic        irq_fire;
    logic [15:0] irq_vector;
    logic [1:0]  q_event;
    logic [15:0] event_q;
    logic [63:0] desc;
    logic [63:0] avail;
    logic [63:0] used;
    logic [15:0] size;
    logic        evidx;
    logic        drv_ok;
    logic        dev_rst;
  } rsp_word_t;

  logic [63:0] dev_feats;
  logic [15:0] max_qsize;
  logic [31:0] dev_sel, drv_sel;
  logic [63:0] drv_feats;
  logic [15:0] cfg_vec;
  logic [7:0]  status, generation;
  logic [15:0] qsel;
  logic [1:0]  isr;
  logic [15:0] qs_size [NQ];
  logic [15:0] qs_vec [NQ];
  logic [15:0] qs_en [NQ];
  logic [63:0] qs_desc [NQ];
  logic [63:0] qs_avail [NQ];
  logic [63:0] qs_used [NQ];
  rsp_word_t   pred;
  rsp_word_t   expected_rsp [$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_rsp.size();

  function automatic void clear_device();
    dev_sel   = '0;
    drv_sel   = '0;
    drv_feats = '0;
    cfg_vec   = vpcc_pkg::NoVector;
    qsel      = '0;
    isr       = '0;
    for (int i = 0; i < NQ; i++) begin
      qs_size[i]  = '0;
      qs_vec[i]   = vpcc_pkg::NoVector;
      qs_en[i]    = '0;
      qs_desc[i]  = '0;
      qs_avail[i] = '0;
      qs_used[i]  = '0;
    end
  endfunction

  function automatic logic [31:0] lane_mask(int unsigned n);
    if (n >= 4) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF >> (32 - 8 * n);
  endfunction

  function automatic logic [31:0] lane_get(logic [5:0] off);
    logic             ok;
    int               q;
    logic [15:0]      sz;
    ok = qsel < NQ;
    q  = ok ? int'(qsel) : 0;
    case (off)
      vpcc_pkg::LaneDevFeatSel: return dev_sel;
      vpcc_pkg::LaneDevFeat: begin
        if (dev_sel == 0) return dev_feats[31:0];
        if (dev_sel == 1) return dev_feats[63:32];
        return '0;
      end
      vpcc_pkg::LaneDrvFeatSel: return drv_sel;
      vpcc_pkg::LaneDrvFeat: begin
        if (drv_sel == 0) return drv_feats[31:0];
        if (drv_sel == 1) return drv_feats[63:32];
        return '0;
      end
      vpcc_pkg::LaneCfgVector: return {16'(NQ), cfg_vec};
      vpcc_pkg::LaneStatus:    return {qsel, generation, status};
      vpcc_pkg::LaneQSize: begin
        if (!ok) return {vpcc_pkg::NoVector, 16'h0};
        sz = qs_size[q] != 0 ? qs_size[q] : max_qsize;
        return {qs_vec[q], sz};
      end
      vpcc_pkg::LaneQEnable: return {qsel, ok ? qs_en[q] : 16'h0};
      vpcc_pkg::LaneDescLo:  return ok ? qs_desc[q][31:0] : '0;
      vpcc_pkg::LaneDescHi:  return ok ? qs_desc[q][63:32] : '0;
      vpcc_pkg::LaneAvailLo: return ok ? qs_avail[q][31:0] : '0;
      vpcc_pkg::LaneAvailHi: return ok ? qs_avail[q][63:32] : '0;
      vpcc_pkg::LaneUsedLo:  return ok ? qs_used[q][31:0] : '0;
      vpcc_pkg::LaneUsedHi:  return ok ? qs_used[q][63:32] : '0;
      default:               return '0;
    endcase
  endfunction

  function automatic void status_set(logic [7:0] ns);
    logic [7:0] adding, eff;
    if (ns == 0) begin
      status = '0;
      clear_device();
      pred.dev_rst = 1'b1;
      return;
    end
    adding = ns & ~status;
    eff    = ns;
    if ((adding & vpcc_pkg::StFeaturesOk) != 0 && (drv_feats & ~dev_feats) != 0) begin
      eff = (eff & ~vpcc_pkg::StFeaturesOk) | vpcc_pkg::StNeedsReset;
    end
    status = eff;
    if ((adding & vpcc_pkg::StDriverOk) != 0) pred.drv_ok = 1'b1;
  endfunction

  function automatic void lane_put(logic [5:0] off, logic [31:0] v);
    logic ok;
    int   q;
    ok = qsel < NQ;
    q  = ok ? int'(qsel) : 0;
    case (off)
      vpcc_pkg::LaneDevFeatSel: dev_sel = v;
      vpcc_pkg::LaneDrvFeatSel: drv_sel = v;
      vpcc_pkg::LaneDrvFeat: begin
        if (drv_sel == 0) drv_feats[31:0] = v;
        else if (drv_sel == 1) drv_feats[63:32] = v;
      end
      vpcc_pkg::LaneCfgVector: cfg_vec = v[15:0];
      vpcc_pkg::LaneStatus: begin
        if (v[7:0] != status) status_set(v[7:0]);
        qsel = v[31:16];
      end
      vpcc_pkg::LaneQSize: if (ok) begin
        if (v[15:0] <= max_qsize) qs_size[q] = v[15:0];
        qs_vec[q] = v[31:16];
      end
      vpcc_pkg::LaneQEnable: if (ok) begin
        qs_en[q] = v[15:0];
        if (v[15:0] != 0 && qs_size[q] != 0) begin
          pred.q_event = vpcc_pkg::EvReady;
          pred.event_q = 16'(q);
          pred.desc    = qs_desc[q];
          pred.avail   = qs_avail[q];
          pred.used    = qs_used[q];
          pred.size    = qs_size[q];
          pred.evidx   = drv_feats[vpcc_pkg::EventIdxBit];
        end else if (v[15:0] == 0) begin
          pred.q_event = vpcc_pkg::EvNotReady;
          pred.event_q = 16'(q);
        end
      end
      vpcc_pkg::LaneDescLo:  if (ok) qs_desc[q][31:0] = v;
      vpcc_pkg::LaneDescHi:  if (ok) qs_desc[q][63:32] = v;
      vpcc_pkg::LaneAvailLo: if (ok) qs_avail[q][31:0] = v;
      vpcc_pkg::LaneAvailHi: if (ok) qs_avail[q][63:32] = v;
      vpcc_pkg::LaneUsedLo:  if (ok) qs_used[q][31:0] = v;
      vpcc_pkg::LaneUsedHi:  if (ok) qs_used[q][63:32] = v;
      default: ;
    endcase
  endfunction

  function automatic void raise_msix(logic [15:0] vec);
    if (vec != vpcc_pkg::NoVector) begin
      pred.irq_fire   = 1'b1;
      pred.irq_vector = vec;
    end
  endfunction

  function automatic void predict_access(logic [2:0] cmd, logic [5:0] off, logic [3:0] sz,
                                         logic [63:0] data, logic [15:0] qidx);
    int unsigned n;
    logic [5:0]  aligned;
    int unsigned sh;
    logic        wide;
    logic [31:0] m, v, cur;
    n       = sz < 4 ? sz : 4;
    aligned = off & 6'h3C;
    sh      = off[1:0] * 8;
    wide    = sz == 8 && off[2:0] == 0;
    pred    = '0;
    case (cmd)
      vpcc_pkg::CmdRead: begin
        if (wide) pred.read_data = {lane_get(off + 6'd4), lane_get(off)};
        else pred.read_data = 64'((lane_get(aligned) >> sh) & lane_mask(n));
      end
      vpcc_pkg::CmdWrite: begin
        if (wide) begin
          lane_put(off, data[31:0]);
          lane_put(off + 6'd4, data[63:32]);
        end else if (n != 0) begin
          m = lane_mask(n);
          v = data[31:0] & m;
          if (sz < 4) begin
            cur = lane_get(aligned);
            cur = (cur & ~(m << sh)) | (v << sh);
            lane_put(aligned, cur);
          end else begin
            lane_put(aligned, v);
          end
        end
      end
      vpcc_pkg::CmdIsrRead: begin
        pred.read_data = 64'(32'(isr) & lane_mask(n));
        isr = '0;
      end
      vpcc_pkg::CmdQueueIrq: begin
        isr = isr | vpcc_pkg::IsrQueue;
        if (qidx < NQ) raise_msix(qs_vec[qidx]);
      end
      vpcc_pkg::CmdConfigIrq: begin
        isr = isr | vpcc_pkg::IsrConfig;
        generation = generation + 8'd1;
        raise_msix(cfg_vec);
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: response %s mismatch: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic compare_rsp();
    rsp_word_t w;
    if (expected_rsp.size() == 0) begin
      $display("%0t: response word with nothing outstanding", $realtime);
      errors++;
      return;
    end
    w = expected_rsp.pop_front();
    if (rsp.read_data !== w.read_data) report("read_data", rsp.read_data, w.read_data);
    if (rsp.interrupt_fire !== w.irq_fire)
      report("interrupt_fire", 64'(rsp.interrupt_fire), 64'(w.irq_fire));
    if (rsp.interrupt_vector !== w.irq_vector)
      report("interrupt_vector", 64'(rsp.interrupt_vector), 64'(w.irq_vector));
    if (rsp.queue_event !== w.q_event)
      report("queue_event", 64'(rsp.queue_event), 64'(w.q_event));
    if (rsp.event_queue !== w.event_q)
      report("event_queue", 64'(rsp.event_queue), 64'(w.event_q));
    if (rsp.ring_desc !== w.desc) report("ring_desc", rsp.ring_desc, w.desc);
    if (rsp.ring_avail !== w.avail) report("ring_avail", rsp.ring_avail, w.avail);
    if (rsp.ring_used !== w.used) report("ring_used", rsp.ring_used, w.used);
    if (rsp.ring_size !== w.size) report("ring_size", 64'(rsp.ring_size), 64'(w.size));
    if (rsp.event_idx_on !== w.evidx)
      report("event_idx_on", 64'(rsp.event_idx_on), 64'(w.evidx));
    if (rsp.driver_ok_pulse !== w.drv_ok)
      report("driver_ok_pulse", 64'(rsp.driver_ok_pulse), 64'(w.drv_ok));
    if (rsp.device_reset_pulse !== w.dev_rst)
      report("device_reset_pulse", 64'(rsp.device_reset_pulse), 64'(w.dev_rst));
  endtask

  initial errors = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_feats  = '0;
      max_qsize  = vpcc_pkg::QueueMaxSizeDef;
      status     = '0;
      generation = '0;
      clear_device();
      expected_rsp.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 4'd0) dev_feats = pwdata;
        else if (paddr == 4'd8) max_qsize = pwdata[15:0];
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) compare_rsp();
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        predict_access(req.cmd, req.offset, req.acc_size, req.write_data, req.queue_index);
        expected_rsp.insert(expected_rsp.size(), pred);
      end
    end
  end
endmodule

FILE: dv/tb_virtio_pci_common_config.sv
// Top of the virtio common-configuration testbench: clock, reset, APB set-up, request
// stimulus and response back-pressure. Depends on vpcc_pkg, both channel interfaces,
// the block and vpcc_access_checker.
module tb_virtio_pci_common_config;
  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          sent;
  bit          gaps_on;
  bit          stim_done;

  vpcc_req_if req ();
  vpcc_rsp_if rsp ();

  virtio_pci_common_config u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req.sink),
    .rsp_o   (rsp.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vpcc_access_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic put_word(logic [2:0] cmd, logic [5:0] off, logic [3:0] sz,
                          logic [63:0] data, logic [15:0] qidx);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 25) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.cmd         <= cmd;
    req.offset      <= off;
    req.acc_size    <= sz;
    req.write_data  <= data;
    req.queue_index <= qidx;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic setup_queue();
    logic [15:0] q;
    q = 16'($urandom_range(0, 9));
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneStatus, 4'd2, 64'(q) << 16 | 64'h0F, 16'h0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneQSize, 4'd4,
             {32'h0, 16'($urandom), 16'($urandom_range(0, 300))}, 16'h0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneDescLo, 4'd8, rand64(), 16'h0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneAvailLo, 4'd8, rand64(), 16'h0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneUsedLo, 4'd8, rand64(), 16'h0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneQEnable, 4'($urandom_range(1, 4)),
             64'($urandom_range(0, 2)), 16'h0);
    put_word(vpcc_pkg::CmdQueueIrq, 6'($urandom), 4'd4, rand64(), q);
  endtask

  task automatic random_word();
    int          r;
    logic [2:0]  cmd;
    logic [5:0]  off;
    logic [3:0]  sz;
    logic [63:0] data;
    logic [15:0] qidx;
    r = $urandom_range(99);
    if (r < 35) cmd = vpcc_pkg::CmdWrite;
    else if (r < 70) cmd = vpcc_pkg::CmdRead;
    else if (r < 78) cmd = vpcc_pkg::CmdIsrRead;
    else if (r < 88) cmd = vpcc_pkg::CmdQueueIrq;
    else if (r < 96) cmd = vpcc_pkg::CmdConfigIrq;
    else cmd = 3'($urandom_range(5, 7));
    off  = $urandom_range(99) < 80 ? 6'($urandom_range(0, 15) * 4) : 6'($urandom);
    sz   = $urandom_range(99) < 85 ? 4'(1 << $urandom_range(0, 3)) : 4'($urandom);
    data = rand64();
    qidx = $urandom_range(99) < 80 ? 16'($urandom_range(0, 9)) : 16'($urandom);
    if ($urandom_range(99) < 80) begin
      case (off & 6'h3C)
        vpcc_pkg::LaneStatus: begin
          case ($urandom_range(0, 5))
            0: data[7:0] = 8'h00;
            1: data[7:0] = 8'h01;
            2: data[7:0] = 8'h03;
            3: data[7:0] = 8'h0B;
            4: data[7:0] = 8'h0F;
            default: ;
          endcase
          data[31:16] = 16'($urandom_range(0, 9));
        end
        vpcc_pkg::LaneQSize: data[15:0] = 16'($urandom_range(0, 300));
        vpcc_pkg::LaneDevFeatSel, vpcc_pkg::LaneDrvFeatSel:
          data[31:0] = $urandom_range(0, 2);
        default: ;
      endcase
    end
    put_word(cmd, off, sz, data, qidx);
  endtask

  task automatic random_phase(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      gaps_on = !(sent % 1000 >= 400 && sent % 1000 < 550);
      if ($urandom_range(99) < 12) setup_queue();
      else random_word();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    int cyc;
    rsp.ready = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 500) begin
        rsp.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        rsp.ready <= 1'b1;
      end else if (cyc > 1200 && cyc < 2000) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= $urandom_range(99) >= 25;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    req.valid       = 1'b0;
    req.cmd         = vpcc_pkg::CmdRead;
    req.offset      = '0;
    req.acc_size    = '0;
    req.write_data  = '0;
    req.queue_index = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sent    = 0;
    gaps_on = 1'b1;
    rst_ni  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_write(4'd0, 64'hF000_0001_2000_00FF);
    apb_write(4'd8, 64'd256);
    put_word(vpcc_pkg::CmdRead, vpcc_pkg::LaneCfgVector, 4'd4, '0, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneDevFeatSel, 4'd4, 64'd1, '0);
    put_word(vpcc_pkg::CmdRead, vpcc_pkg::LaneDevFeat, 4'd4, '0, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneDrvFeatSel, 4'd4, 64'd0, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneDrvFeat, 4'd4, 64'h2000_0001, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneStatus, 4'd1, 64'h0B, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneStatus, 4'd1, 64'h0F, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneQSize, 4'd4, 64'h0003_0010, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneDescLo, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneAvailLo, 4'd8, 64'h8000_0000_0000_0001, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneUsedLo, 4'd8, 64'h1234_5678_9ABC_DEF0, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneQEnable, 4'd2, 64'h1, '0);
    put_word(vpcc_pkg::CmdQueueIrq, '0, 4'd4, '0, 16'd0);
    put_word(vpcc_pkg::CmdQueueIrq, '0, 4'd4, '0, 16'hFFFF);
    put_word(vpcc_pkg::CmdConfigIrq, '0, 4'd4, '0, '0);
    put_word(vpcc_pkg::CmdWrite, 6'h10, 4'd2, 64'h5, '0);
    put_word(vpcc_pkg::CmdConfigIrq, '0, 4'd4, '0, '0);
    put_word(vpcc_pkg::CmdIsrRead, 6'h3F, 4'd4, '0, '0);
    put_word(vpcc_pkg::CmdWrite, 6'h16, 4'd2, 64'hC, '0);
    put_word(vpcc_pkg::CmdRead, vpcc_pkg::LaneQSize, 4'd4, '0, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneQEnable, 4'd4, '0, '0);
    put_word(vpcc_pkg::CmdWrite, vpcc_pkg::LaneStatus, 4'd1, 64'h0, '0);
    put_word(vpcc_pkg::CmdWrite, 6'h03, 4'd5, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    put_word(3'd7, 6'h3F, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    put_word(vpcc_pkg::CmdRead, vpcc_pkg::LaneStatus, 4'd0, '0, '0);
    random_phase(250);
    drain();
    apb_write(4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(4'd8, 64'd32768);
    random_phase(250);
    drain();
    apb_write(4'd0, 64'h0);
    apb_write(4'd8, 64'h0);
    random_phase(250);
    drain();
    apb_write(4'd0, rand64());
    apb_write(4'd8, 64'($urandom_range(0, 32768)));
    random_phase(250);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
